// ===== rtl/vne_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vne_pkg - shared types and constants of the voxel neighbour enumerator
// Geometry limits, register indices, transaction payloads and queue entry.
// ----------------------------------------------------------------------------
package vne_pkg;

	localparam int MAX_RES    = 1024;
	localparam int COORD_BITS = 32;
	localparam int COORD_W    = $clog2(MAX_RES);      // voxel coordinate
	localparam int RES_W      = 11;                    // resolution register
	localparam int VLEN_W     = 31;
	localparam int QBITS      = COORD_W + 2;           // quotient incl. overflow bit
	localparam int STEP_W     = $clog2(QBITS);
	localparam int DIV_W      = VLEN_W + QBITS - 1;
	localparam int IDX_W      = 30;
	localparam int T_W        = 2 * COORD_W;
	localparam int WH_W       = 2 * COORD_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int Q_DEPTH    = 2;
	localparam int QPTR_W     = $clog2(Q_DEPTH);
	localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

	// register indices
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VLEN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RES_X    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RES_Y    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RES_Z    = 3'd6;

	// neighbour positions in emission order, per axis
	localparam logic [1:0] X_CTR   = 2'd0;
	localparam logic [1:0] X_PLUS  = 2'd1;
	localparam logic [1:0] X_MINUS = 2'd2;
	localparam logic [1:0] Y_PLUS  = 2'd0;
	localparam logic [1:0] Y_MINUS = 2'd1;
	localparam logic [1:0] Y_CTR   = 2'd2;
	localparam logic [1:0] Z_CTR   = 2'd0;
	localparam logic [1:0] Z_PLUS  = 2'd1;
	localparam logic [1:0] Z_MINUS = 2'd2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic [IDX_W-1:0] cell_index;
		logic             inside_res;
		logic             last;
	} result_t;

	// effective geometry, as seen by the front end
	typedef struct packed {
		logic signed [COORD_BITS-1:0] origin_x;
		logic signed [COORD_BITS-1:0] origin_y;
		logic signed [COORD_BITS-1:0] origin_z;
		logic [VLEN_W-1:0]            vlen;
		logic [RES_W-1:0]             res_x;
		logic [RES_W-1:0]             res_y;
		logic [RES_W-1:0]             res_z;
	} geom_t;

	// one classified point, handed from front to back
	typedef struct packed {
		logic             in_grid;
		logic [IDX_W-1:0] base;
		logic [RES_W-1:0] w;
		logic [WH_W-1:0]  wh;
		logic             xp;
		logic             xm;
		logic             yp;
		logic             ym;
		logic             zp;
		logic             zm;
	} ent_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_DIV,
		FE_CALC,
		FE_PUSH
	} fe_state_t;

	function automatic logic [RES_W-1:0] eff_res(input logic [RES_W-1:0] r);
		logic [RES_W-1:0] v;
		if (r == '0)
			v = RES_W'(1);
		else if (r > RES_W'(MAX_RES))
			v = RES_W'(MAX_RES);
		else
			v = r;
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/vne_axis_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vne_axis_div - per-axis offset and restoring divider
// Forms point - origin and divides by the voxel length, one quotient bit a
// cycle, MSB first. The top quotient bit flags an out-of-range quotient.
// ----------------------------------------------------------------------------
module vne_axis_div (
	input  wire logic                                  clk,
	input  wire logic                                  load,
	input  wire logic                                  step,
	input  wire logic signed [vne_pkg::COORD_BITS-1:0] point,
	input  wire logic signed [vne_pkg::COORD_BITS-1:0] origin,
	input  wire logic [vne_pkg::VLEN_W-1:0]            vlen,
	output logic                                       neg,
	output logic [vne_pkg::QBITS-1:0]                  quot
);
	import vne_pkg::*;

	logic [COORD_BITS:0]   diff;
	logic [COORD_BITS-1:0] rem_q;
	logic [DIV_W-1:0]      div_q;
	logic [QBITS-1:0]      quot_q;
	logic                  neg_q;
	logic                  ge;

	assign diff = {point[COORD_BITS-1], point} - {origin[COORD_BITS-1], origin};
	assign ge   = {(DIV_W-COORD_BITS)'(0), rem_q} >= div_q;

	always_ff @(posedge clk) begin
		if (load) begin
			neg_q  <= diff[COORD_BITS];
			rem_q  <= diff[COORD_BITS-1:0];
			div_q  <= {vlen, (QBITS-1)'(0)};
			quot_q <= '0;
		end else if (step) begin
			// divisor below remainder here, so its upper bits are zero
			if (ge)
				rem_q <= rem_q - div_q[COORD_BITS-1:0];
			quot_q <= {quot_q[QBITS-2:0], ge};
			div_q  <= div_q >> 1;
		end
	end

	assign neg  = neg_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

// ===== rtl/vne_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vne_front - point intake and classification
// Divides all three axes in parallel, checks the grid bounds, works out the
// base index and neighbour validity, and pushes one entry to the queue.
// ----------------------------------------------------------------------------
module vne_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire vne_pkg::point_t point,
	input  wire vne_pkg::geom_t  geom,
	input  wire logic            q_full,
	output logic                 busy,
	output logic                 push,
	output vne_pkg::ent_t        push_ent
);
	import vne_pkg::*;

	fe_state_t         state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              load, step;

	logic              neg_x, neg_y, neg_z;
	logic [QBITS-1:0]  q_x, q_y, q_z;
	logic              in_x, in_y, in_z;
	logic [COORD_W-1:0] cx, cy, cz;
	logic [WH_W-1:0]   t_full, wh_full;

	logic                   inside_s1;
	logic [COORD_W-1:0]     cx_s1;
	logic [T_W-1:0]         t_s1;
	logic [WH_W-1:0]        wh_s1;
	logic                   xp_s1, xm_s1, yp_s1, ym_s1, zp_s1, zm_s1;
	logic [T_W+RES_W-1:0]   base_full;

	vne_axis_div u_div_x (
		.clk(clk), .load(load), .step(step), .point(point.point_x),
		.origin(geom.origin_x), .vlen(geom.vlen), .neg(neg_x), .quot(q_x)
	);
	vne_axis_div u_div_y (
		.clk(clk), .load(load), .step(step), .point(point.point_y),
		.origin(geom.origin_y), .vlen(geom.vlen), .neg(neg_y), .quot(q_y)
	);
	vne_axis_div u_div_z (
		.clk(clk), .load(load), .step(step), .point(point.point_z),
		.origin(geom.origin_z), .vlen(geom.vlen), .neg(neg_z), .quot(q_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (load)
				step_q <= STEP_W'(QBITS - 1);
			else if (step)
				step_q <= step_q - STEP_W'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		step    = 1'b0;
		push    = 1'b0;
		busy    = 1'b1;
		case (state_q)
			FE_IDLE: begin
				busy = 1'b0;
				if (start) begin
					load    = 1'b1;
					state_d = FE_DIV;
				end
			end
			FE_DIV: begin
				step = 1'b1;
				if (step_q == '0)
					state_d = FE_CALC;
			end
			FE_CALC: state_d = FE_PUSH;
			FE_PUSH: begin
				if (!q_full) begin
					push    = 1'b1;
					state_d = FE_IDLE;
				end
			end
			default: state_d = FE_IDLE;
		endcase
	end

	// bounds: non-negative, overflow bit clear, below resolution
	assign in_x = !neg_x && !q_x[QBITS-1] && (q_x[QBITS-2:0] < geom.res_x);
	assign in_y = !neg_y && !q_y[QBITS-1] && (q_y[QBITS-2:0] < geom.res_y);
	assign in_z = !neg_z && !q_z[QBITS-1] && (q_z[QBITS-2:0] < geom.res_z);
	assign cx   = q_x[COORD_W-1:0];
	assign cy   = q_y[COORD_W-1:0];
	assign cz   = q_z[COORD_W-1:0];

	assign t_full  = WH_W'(cz * geom.res_y) + WH_W'(cy);
	assign wh_full = WH_W'(geom.res_x * geom.res_y);

	always_ff @(posedge clk) begin
		if (state_q == FE_CALC) begin
			inside_s1 <= in_x && in_y && in_z;
			cx_s1     <= cx;
			t_s1      <= t_full[T_W-1:0];
			wh_s1     <= wh_full;
			xm_s1     <= cx != '0;
			ym_s1     <= cy != '0;
			zm_s1     <= cz != '0;
			xp_s1     <= (RES_W'(cx) + RES_W'(1)) < geom.res_x;
			yp_s1     <= (RES_W'(cy) + RES_W'(1)) < geom.res_y;
			zp_s1     <= (RES_W'(cz) + RES_W'(1)) < geom.res_z;
		end
	end

	assign base_full = t_s1 * geom.res_x + (T_W+RES_W)'(cx_s1);

	always_comb begin
		push_ent.in_grid = inside_s1;
		push_ent.base    = base_full[IDX_W-1:0];
		push_ent.w       = geom.res_x;
		push_ent.wh      = wh_s1;
		push_ent.xp      = xp_s1;
		push_ent.xm      = xm_s1;
		push_ent.yp      = yp_s1;
		push_ent.ym      = ym_s1;
		push_ent.zp      = zp_s1;
		push_ent.zm      = zm_s1;
	end

endmodule
`default_nettype wire

// ===== rtl/vne_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vne_queue - short FIFO between front and back end
// Holds classified points so the front can take the next point while the
// back end is still listing neighbours.
// ----------------------------------------------------------------------------
module vne_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire vne_pkg::ent_t push_ent,
	input  wire logic          pop,
	output logic               full,
	output logic               head_valid,
	output vne_pkg::ent_t      head
);
	import vne_pkg::*;

	ent_t              mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_ent;
	end

	assign full       = cnt_q == QCNT_W'(Q_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

// ===== rtl/vne_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vne_back - neighbour sequencer
// Walks the 27 candidate positions of the queue head, one per cycle, and
// strobes the in-grid ones out. Stops at the last in-grid neighbour.
// ----------------------------------------------------------------------------
module vne_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire vne_pkg::ent_t head,
	output logic               pop,
	output logic               result_valid,
	output vne_pkg::result_t   result
);
	import vne_pkg::*;

	logic [1:0]       a_q, b_q, c_q;
	logic [1:0]       last_a, last_c;
	logic             ok_x, ok_y, ok_z, cand_ok, is_last;
	logic [IDX_W-1:0] off_x, off_y, off_z, idx;
	logic             result_valid_q;
	result_t          result_q;

	always_comb begin
		case (a_q)
			X_CTR:   begin ok_x = 1'b1;    off_x = '0; end
			X_PLUS:  begin ok_x = head.xp; off_x = IDX_W'(1); end
			X_MINUS: begin ok_x = head.xm; off_x = '1; end
			default: begin ok_x = 1'b0;    off_x = '0; end
		endcase
		case (b_q)
			Y_PLUS:  begin ok_y = head.yp; off_y = IDX_W'(head.w); end
			Y_MINUS: begin ok_y = head.ym; off_y = IDX_W'(0) - IDX_W'(head.w); end
			Y_CTR:   begin ok_y = 1'b1;    off_y = '0; end
			default: begin ok_y = 1'b0;    off_y = '0; end
		endcase
		case (c_q)
			Z_CTR:   begin ok_z = 1'b1;    off_z = '0; end
			Z_PLUS:  begin ok_z = head.zp; off_z = IDX_W'(head.wh); end
			Z_MINUS: begin ok_z = head.zm; off_z = IDX_W'(0) - IDX_W'(head.wh); end
			default: begin ok_z = 1'b0;    off_z = '0; end
		endcase
	end

	// the centre is always in the grid, so the final emitted candidate is
	// the last valid position on each axis
	assign last_a  = head.xm ? X_MINUS : (head.xp ? X_PLUS : X_CTR);
	assign last_c  = head.zm ? Z_MINUS : (head.zp ? Z_PLUS : Z_CTR);
	assign is_last = (a_q == last_a) && (b_q == Y_CTR) && (c_q == last_c);
	assign cand_ok = ok_x && ok_y && ok_z;
	assign idx     = head.base + off_x + off_y + off_z;
	assign pop     = head_valid && (!head.in_grid || is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q            <= X_CTR;
			b_q            <= Y_PLUS;
			c_q            <= Z_CTR;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= head_valid && (!head.in_grid || cand_ok);
			if (pop) begin
				a_q <= X_CTR;
				b_q <= Y_PLUS;
				c_q <= Z_CTR;
			end else if (head_valid) begin
				if (c_q == Z_MINUS) begin
					c_q <= Z_CTR;
					if (b_q == Y_CTR) begin
						b_q <= Y_PLUS;
						a_q <= a_q + 2'd1;
					end else begin
						b_q <= b_q + 2'd1;
					end
				end else begin
					c_q <= c_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head.in_grid) begin
			result_q.cell_index <= idx;
			result_q.inside_res <= 1'b1;
			result_q.last       <= is_last;
		end else begin
			result_q.cell_index <= '0;
			result_q.inside_res <= 1'b0;
			result_q.last       <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

// ===== rtl/voxel_neighbor_enumerator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_neighbor_enumerator - 27-neighbourhood voxel index lister
// Maps a Q15.16 point onto a uniform voxel grid and lists the linear indices
// of its voxel and in-grid neighbours; an outside point gives one result.
// ----------------------------------------------------------------------------
// A point is taken when start is high and busy low. The front end then stays
// busy through 12 divider steps (one quotient bit per cycle on each axis),
// one bound check, one base-index multiply and the queue write, which waits
// while both queue entries are full; a new point can be issued once busy falls.
// The back end walks the candidate positions one per clock until the last
// in-grid neighbour: at most 27 positions for a point inside the grid, one
// for a point outside it. Results appear on result for one cycle each, marked
// by result_valid, and cannot be held off. Write the registers only while
// no point is in flight.
// ----------------------------------------------------------------------------
module voxel_neighbor_enumerator (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire vne_pkg::point_t                  point,
	input  wire logic                             cfg_we,
	input  wire logic [vne_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [vne_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                                  result_valid,
	output vne_pkg::result_t                      result
);
	import vne_pkg::*;

	logic signed [COORD_BITS-1:0] origin_x_q, origin_y_q, origin_z_q;
	logic [VLEN_W-1:0]            vlen_q;
	logic [RES_W-1:0]             res_x_q, res_y_q, res_z_q;
	geom_t                        geom;

	logic q_full, push, pop, head_valid;
	ent_t push_ent, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			vlen_q     <= VLEN_W'(65536);
			res_x_q    <= RES_W'(1);
			res_y_q    <= RES_W'(1);
			res_z_q    <= RES_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_data;
				REG_ORIGIN_Y: origin_y_q <= cfg_data;
				REG_ORIGIN_Z: origin_z_q <= cfg_data;
				REG_VLEN:     vlen_q     <= cfg_data[VLEN_W-1:0];
				REG_RES_X:    res_x_q    <= cfg_data[RES_W-1:0];
				REG_RES_Y:    res_y_q    <= cfg_data[RES_W-1:0];
				REG_RES_Z:    res_z_q    <= cfg_data[RES_W-1:0];
				default: ;
			endcase
		end
	end

	// zero length acts as the smallest step; resolutions clamp to [1, MAX_RES]
	always_comb begin
		geom.origin_x = origin_x_q;
		geom.origin_y = origin_y_q;
		geom.origin_z = origin_z_q;
		geom.vlen     = (vlen_q == '0) ? VLEN_W'(1) : vlen_q;
		geom.res_x    = eff_res(res_x_q);
		geom.res_y    = eff_res(res_y_q);
		geom.res_z    = eff_res(res_z_q);
	end

	vne_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .point(point), .geom(geom),
		.q_full(q_full), .busy(busy), .push(push), .push_ent(push_ent)
	);

	vne_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_ent(push_ent), .pop(pop),
		.full(q_full), .head_valid(head_valid), .head(head)
	);

	vne_back u_back (
		.clk(clk), .arst_n(arst_n), .head_valid(head_valid), .head(head),
		.pop(pop), .result_valid(result_valid), .result(result)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("queue written while full");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("front end not busy after taking a point");

	a_outside_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.inside_res |-> result.last && result.cell_index == '0)
		else $error("outside result not a single zero-index final transaction");

endmodule
`default_nettype wire

// ===== tb/voxel_neighbor_enumerator_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_neighbor_enumerator_tb - self-checking bench for the voxel lister
// Walks a table of directed points and register writes, then runs six random
// grid geometries with points aimed at cells, edges and just past the grid.
// Every result is checked field by field against the table or a predictor.
// ----------------------------------------------------------------------------
module voxel_neighbor_enumerator_tb;
	import vne_pkg::*;

	localparam int LIMIT = 300000;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;	// unmapped index
	localparam result_t FIRST_CELL   = {30'd0, 1'b1, 1'b1};
	localparam result_t OUTSIDE_GRID = {30'd0, 1'b0, 1'b1};

	typedef struct packed {
		logic                  is_write;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] data;
		point_t                pt;
		logic                  typed;
		result_t               want;
	} step_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	point_t                point;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  result_valid;
	result_t               result;

	// predictor's copy of the registers
	logic signed [31:0] org_x, org_y, org_z;
	logic [30:0]        vlen;
	logic [10:0]        rsx, rsy, rsz;

	result_t cells_due[$];
	step_t   directed_steps[$];
	int      idle_pct;
	int      errors;
	int      cycles;
	int      points_sent;
	int      results_seen;
	int      inside_seen;

	voxel_neighbor_enumerator DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.point       (point),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d indices still due", cycles, cells_due.size());
			$display("voxel_neighbor_enumerator_tb: errors");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	function automatic longint eff_res_of(input logic [10:0] r);
		if (r == 11'd0)
			return 1;
		if (r > MAX_RES)
			return MAX_RES;
		return longint'(r);
	endfunction

	function automatic longint eff_len();
		return (vlen == 31'd0) ? 1 : longint'(vlen);
	endfunction

	// voxel coordinate along one axis; false when it leaves [0, r)
	function automatic bit axis_cell(input logic signed [31:0] p, input logic signed [31:0] o,
			input longint r, output longint c);
		longint d;
		d = longint'(p) - longint'(o);
		c = 0;
		if (d < 0)
			return 1'b0;
		c = d / eff_len();
		return c < r;
	endfunction

	task automatic predict_cells(input point_t p);
		longint  w, h, dd, cx, cy, cz, x, y, z, idx;
		bit      inx, iny, inz;
		result_t batch[$];
		result_t r;
		w = eff_res_of(rsx);
		h = eff_res_of(rsy);
		dd = eff_res_of(rsz);
		inx = axis_cell($signed(p.point_x), org_x, w, cx);
		iny = axis_cell($signed(p.point_y), org_y, h, cy);
		inz = axis_cell($signed(p.point_z), org_z, dd, cz);
		if (!(inx && iny && inz)) begin
			cells_due = {cells_due, OUTSIDE_GRID};
			return;
		end
		// columns x, x+1, x-1; rows y+1, y-1, y; layers z, z+1, z-1
		for (int a = 0; a < 3; a++) begin
			x = cx + ((a == 2) ? -1 : a);
			if (x < 0 || x >= w)
				continue;
			for (int b = 0; b < 3; b++) begin
				y = cy + ((b == 0) ? 1 : (b == 1) ? -1 : 0);
				if (y < 0 || y >= h)
					continue;
				for (int c = 0; c < 3; c++) begin
					z = cz + ((c == 2) ? -1 : c);
					if (z < 0 || z >= dd)
						continue;
					idx = z * w * h + y * w + x;
					r.cell_index = idx[IDX_W-1:0];
					r.inside_res = 1'b1;
					r.last = 1'b0;
					batch = {batch, r};
				end
			end
		end
		batch[batch.size() - 1].last = 1'b1;
		cells_due = {cells_due, batch};
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid) begin
			results_seen++;
			if (result.inside_res)
				inside_seen++;
			if (cells_due.size() == 0) begin
				report_error($sformatf("unexpected transaction, cell_index %0d",
					result.cell_index));
			end else begin
				want = cells_due.pop_front();
				if (result.cell_index !== want.cell_index)
					report_error($sformatf("cell_index %0d, expected %0d",
						result.cell_index, want.cell_index));
				if (result.inside_res !== want.inside_res)
					report_error($sformatf("inside_res %b, expected %b",
						result.inside_res, want.inside_res));
				if (result.last !== want.last)
					report_error($sformatf("last %b, expected %b (cell_index %0d)",
						result.last, want.last, want.cell_index));
			end
		end
	end

	// returns at the edge that accepts the point; start stays high until the next call
	task automatic issue_point(input point_t p);
		int gap;
		gap = 0;
		while (gap < 24 && $urandom_range(0, 99) < idle_pct)
			gap++;
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
			point <= point_t'({$urandom, $urandom, $urandom});
		end
		@(negedge clk);
		start <= 1'b1;
		point <= p;
		do @(posedge clk); while (busy);
		points_sent++;
	endtask

	// every point yields at least one index, so an empty queue and low busy means idle
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (cells_due.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ORIGIN_X: org_x = val;
			REG_ORIGIN_Y: org_y = val;
			REG_ORIGIN_Z: org_z = val;
			REG_VLEN:     vlen = val[30:0];
			REG_RES_X:    rsx = val[10:0];
			REG_RES_Y:    rsy = val[10:0];
			REG_RES_Z:    rsz = val[10:0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] near_zero();
		return 32'($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000;
	endfunction

	task automatic set_geometry(input int kind);
		logic [31:0] ox, oy, oz, vl, rx, ry, rz;
		ox = near_zero();
		oy = near_zero();
		oz = near_zero();
		vl = $urandom_range(1, 32'h0010_0000);
		rx = $urandom_range(1, 6);
		ry = $urandom_range(1, 6);
		rz = $urandom_range(1, 6);
		case (kind)
			1: begin
				vl = $urandom_range(1, 8);
				rx = 32'd1024;
				ry = $urandom_range(1, 1024);
				rz = $urandom_range(512, 1024);
			end
			2: begin
				vl = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
				ox = 32'h8000_0000 + $urandom_range(0, 255);
				oy = 32'h8000_0000 + $urandom_range(0, 255);
				oz = $urandom;
				rx = $urandom_range(1, 3);
				ry = 32'd0;
				rz = $urandom_range(2, 4);
			end
			3: begin
				ox = $urandom;
				oy = $urandom;
				oz = $urandom;
				vl = $urandom;
				rx = $urandom;
				ry = $urandom;
				rz = $urandom;
			end
			4: begin
				vl = 32'd0;
				rx = 32'd0;
				ry = 32'hFFFF_FFFF;
				rz = $urandom_range(1, 4);
			end
			default: ;
		endcase
		drain();
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_VLEN, vl);
		write_reg(REG_RES_X, rx);
		write_reg(REG_RES_Y, ry);
		write_reg(REG_RES_Z, rz);
	endtask

	// lands in a chosen cell, often at the first or last one, or one step outside
	function automatic logic [31:0] aim_axis(input logic signed [31:0] o, input longint r);
		longint v, c, pos;
		v = eff_len();
		case ($urandom_range(0, 9))
			0: c = -1;
			1: c = r;
			2: c = 0;
			3: c = r - 1;
			default: c = $urandom_range(0, 32'(r - 1));
		endcase
		pos = longint'(o) + c * v + longint'($urandom_range(0, 32'(v - 1)));
		return pos[31:0];
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		step_t s;
		s = '0;
		s.is_write = 1'b1;
		s.reg_idx = idx;
		s.data = val;
		directed_steps = {directed_steps, s};
	endfunction

	function automatic void add_point(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic typed, input result_t want);
		step_t s;
		s = '0;
		s.pt = {x, y, z};
		s.typed = typed;
		s.want = want;
		directed_steps = {directed_steps, s};
	endfunction

	initial begin
		point_t p;
		arst_n = 1'b0;
		start = 1'b0;
		point = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		org_x = '0;
		org_y = '0;
		org_z = '0;
		vlen = 31'd65536;
		rsx = 11'd1;
		rsy = 11'd1;
		rsz = 11'd1;
		idle_pct = 20;

		// single 1x1x1 grid of unit voxels out of reset
		add_point(32'h0, 32'h0, 32'h0, 1'b1, FIRST_CELL);
		add_point(32'hFFFF, 32'hFFFF, 32'hFFFF, 1'b1, FIRST_CELL);
		add_point(32'h1_0000, 32'h0, 32'h0, 1'b1, OUTSIDE_GRID);
		add_point(32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1, OUTSIDE_GRID);
		add_point(32'h0, 32'h0, 32'h1_0000, 1'b1, OUTSIDE_GRID);
		add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, OUTSIDE_GRID);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, OUTSIDE_GRID);
		// zero resolution behaves as one voxel
		add_write(REG_RES_X, 32'h0);
		add_point(32'h0, 32'h0, 32'h0, 1'b1, FIRST_CELL);
		// zero voxel length behaves as the smallest step
		add_write(REG_VLEN, 32'h0);
		add_point(32'h0, 32'h0, 32'h0, 1'b1, FIRST_CELL);
		add_point(32'h1, 32'h0, 32'h0, 1'b1, OUTSIDE_GRID);
		// unmapped index must change nothing
		add_write(REG_NONE, 32'hFFFF_FFFF);
		add_point(32'h0, 32'h0, 32'h0, 1'b1, FIRST_CELL);
		// oversized resolutions saturate to the full 1024-cube
		add_write(REG_RES_X, 32'hFFFF_FFFF);
		add_write(REG_RES_Y, 32'h400);
		add_write(REG_RES_Z, 32'h401);
		add_write(REG_VLEN, 32'h1);
		add_point(32'h3FF, 32'h3FF, 32'h3FF, 1'b0, '0);
		add_point(32'h400, 32'h0, 32'h0, 1'b1, OUTSIDE_GRID);
		add_point(32'h0, 32'h0, 32'h0, 1'b0, '0);
		add_point(32'h5, 32'h6, 32'h7, 1'b0, '0);
		// widest differences: extreme origin against extreme point
		add_write(REG_ORIGIN_X, 32'h8000_0000);
		add_write(REG_VLEN, 32'hFFFF_FFFF);
		add_point(32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, '0);
		add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0, '0);
		add_write(REG_ORIGIN_Y, 32'h7FFF_FFFF);
		add_write(REG_ORIGIN_Z, 32'h7FFF_FFFF);
		add_point(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, OUTSIDE_GRID);
		add_point(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0);
		// small uneven grid
		add_write(REG_ORIGIN_X, 32'h0);
		add_write(REG_ORIGIN_Y, 32'h0);
		add_write(REG_ORIGIN_Z, 32'h0);
		add_write(REG_VLEN, 32'h1_0000);
		add_write(REG_RES_X, 32'h1);
		add_write(REG_RES_Y, 32'h2);
		add_write(REG_RES_Z, 32'h3);
		add_point(32'h0, 32'h1_FFFF, 32'h2_FFFF, 1'b0, '0);
		add_point(32'hFFFF, 32'h1_0000, 32'h1_0000, 1'b0, '0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_steps[i]) begin
			if (directed_steps[i].is_write) begin
				drain();
				write_reg(directed_steps[i].reg_idx, directed_steps[i].data);
			end else begin
				issue_point(directed_steps[i].pt);
				if (directed_steps[i].typed)
					cells_due = {cells_due, directed_steps[i].want};
				else
					predict_cells(directed_steps[i].pt);
			end
		end

		for (int ph = 0; ph < 6; ph++) begin
			idle_pct = (ph < 2) ? 33 : (ph < 4) ? 63 : 0;
			set_geometry(ph);
			repeat (80) begin
				if ($urandom_range(0, 3) == 0) begin
					p = point_t'({$urandom, $urandom, $urandom});
				end else begin
					p.point_x = aim_axis(org_x, eff_res_of(rsx));
					p.point_y = aim_axis(org_y, eff_res_of(rsy));
					p.point_z = aim_axis(org_z, eff_res_of(rsz));
				end
				issue_point(p);
				predict_cells(p);
			end
		end

		drain();
		repeat (40) @(posedge clk);
		$display("%0d points over the directed table and six random geometries",
			points_sent);
		$display("%0d indices checked (%0d inside), %0d cycles, %0d mismatches",
			results_seen, inside_seen, cycles, errors);
		if (errors == 0)
			$display("voxel_neighbor_enumerator_tb: clean");
		else
			$display("voxel_neighbor_enumerator_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire
